// File: rtl/barometric_pressure_compensation_core_macros.svh
// Assertion macros shared by the compensation core checkers
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_CORE_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define BPC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compensation core check failed");

// Next-cycle implication, sampled on clk, off during reset
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compensation core check failed");

`endif

// File: rtl/bpc_pkg.sv
// Shared types and constants for the pressure compensation core
`default_nettype none

package bpc_pkg;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    // Formula constants
    localparam logic signed [29:0] B6_OFFSET = 30'sd4000;
    localparam logic signed [63:0] B4_BIAS   = 64'sd32768;
    localparam logic [15:0]        B7_SCALE  = 16'd50000;
    localparam logic [11:0]        C_SQ      = 12'd3038;
    localparam logic signed [14:0] C_LIN     = -15'sd7357;
    localparam logic signed [63:0] C_OFF     = 64'sd3791;

    // Temperature divider: 27-bit dividend, 18-bit divisor
    localparam int D1_N   = 27;
    localparam int D1_W   = 18;
    localparam int D1_BPS = 3;
    localparam int D1_STG = D1_N / D1_BPS;

    // Pressure divider: 32-bit dividend, 17-bit divisor
    localparam int D2_N   = 32;
    localparam int D2_W   = 17;
    localparam int D2_BPS = 4;
    localparam int D2_STG = D2_N / D2_BPS;

    // Unpacked calibration set
    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } cfg_t;

    // Temperature section result
    typedef struct packed {
        logic signed [28:0] b5;
        logic signed [15:0] t;
        logic               err;
        logic [18:0]        up;
    } tmp_t;

    // Divider operands for pressure
    typedef struct packed {
        logic [31:0]        b7;
        logic [16:0]        b4;
        logic signed [15:0] t;
        logic               err;
    } pdin_t;

    // Raw pressure quotient
    typedef struct packed {
        logic [31:0]        p;
        logic signed [15:0] t;
        logic               err;
    } praw_t;

    // Final result beat
    typedef struct packed {
        logic signed [15:0] t;
        logic [17:0]        pa;
        logic               err;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/bpc_temp.sv
// Temperature section: X1, pipelined signed divide for X2, B5 and tenths
`default_nettype none

module bpc_temp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [15:0]        raw_temp,
    input  logic [18:0]        raw_pressure,
    input  bpc_pkg::cfg_t      cfg,
    output logic               out_vld,
    output bpc_pkg::tmp_t      out_data
);

    typedef struct packed {
        logic signed [19:0] x1;
        logic               neg;
        logic               zero;
        logic [18:0]        up;
    } side_t;

    // Stage 1: (UT - AC6) * AC5
    logic                s1_vld_reg;
    logic signed [34:0]  s1_prod_reg;
    logic [18:0]         s1_up_reg;
    logic signed [17:0]  diff;
    logic signed [34:0]  prod_next;

    // Stage 2: X1 and divisor
    logic                s2_vld_reg;
    logic signed [19:0]  s2_x1_reg;
    logic signed [20:0]  s2_den_reg;
    logic [18:0]         s2_up_reg;
    logic signed [19:0]  x1_next;
    logic signed [20:0]  den_next;

    // Divider pipe, entry 0 is the operand setup
    logic                 dv_vld_reg  [0:bpc_pkg::D1_STG];
    logic [bpc_pkg::D1_W-1:0] dv_rem_reg [0:bpc_pkg::D1_STG];
    logic [bpc_pkg::D1_N-1:0] dv_nq_reg  [0:bpc_pkg::D1_STG];
    logic [bpc_pkg::D1_W-1:0] dv_den_reg [0:bpc_pkg::D1_STG];
    side_t                dv_side_reg [0:bpc_pkg::D1_STG];
    logic [bpc_pkg::D1_W-1:0] dv_rem_next [1:bpc_pkg::D1_STG];
    logic [bpc_pkg::D1_N-1:0] dv_nq_next  [1:bpc_pkg::D1_STG];

    logic signed [16:0]  mcw;
    logic signed [16:0]  mcm;
    logic signed [20:0]  denw;
    side_t               side0_next;

    // Output stage
    logic                out_vld_reg;
    bpc_pkg::tmp_t       out_reg;
    bpc_pkg::tmp_t       out_next;

    // Stage 1 math
    always_comb
    begin
        diff      = $signed({2'b00, raw_temp}) - $signed({2'b00, cfg.ac6});
        prod_next = diff * $signed({1'b0, cfg.ac5});
    end

    // Stage 2 math: arithmetic shift by 15 is the upper bits
    always_comb
    begin
        x1_next  = s1_prod_reg[34:15];
        den_next = 21'(x1_next) + 21'(cfg.md);
    end

    // Divider setup: magnitudes and quotient sign
    always_comb
    begin
        mcw             = 17'(cfg.mc);
        mcm             = mcw[16] ? -mcw : mcw;
        denw            = s2_den_reg[20] ? -s2_den_reg : s2_den_reg;
        side0_next.x1   = s2_x1_reg;
        side0_next.neg  = cfg.mc[15] ^ s2_den_reg[20];
        side0_next.zero = (s2_den_reg == 21'sd0);
        side0_next.up   = s2_up_reg;
    end

    // Restoring divide, D1_BPS quotient bits per stage
    always_comb
    begin
        logic [bpc_pkg::D1_W-1:0] r;
        logic [bpc_pkg::D1_N-1:0] q;
        logic [bpc_pkg::D1_W:0]   tmp;
        for (int s = 1; s <= bpc_pkg::D1_STG; s++)
        begin
            r = dv_rem_reg[s-1];
            q = dv_nq_reg[s-1];
            for (int i = 0; i < bpc_pkg::D1_BPS; i++)
            begin
                tmp = {r, q[bpc_pkg::D1_N-1]};
                q   = {q[bpc_pkg::D1_N-2:0], 1'b0};
                if (tmp >= {1'b0, dv_den_reg[s-1]})
                begin
                    tmp  = tmp - {1'b0, dv_den_reg[s-1]};
                    q[0] = 1'b1;
                end
                r = tmp[bpc_pkg::D1_W-1:0];
            end
            dv_rem_next[s] = r;
            dv_nq_next[s]  = q;
        end
    end

    // B5 = X1 + X2, T = (B5 + 8) >> 4, saturated
    always_comb
    begin
        logic signed [27:0] qs;
        logic signed [27:0] x2;
        logic signed [28:0] b5;
        logic signed [28:0] tq;
        qs = $signed({1'b0, dv_nq_reg[bpc_pkg::D1_STG]});
        x2 = dv_side_reg[bpc_pkg::D1_STG].neg ? -qs : qs;
        b5 = 29'(dv_side_reg[bpc_pkg::D1_STG].x1) + 29'(x2);
        tq = (b5 + 29'sd8) >>> 4;
        out_next.b5  = b5;
        out_next.err = dv_side_reg[bpc_pkg::D1_STG].zero;
        out_next.up  = dv_side_reg[bpc_pkg::D1_STG].up;
        if (tq > 29'sd32767)
        begin
            out_next.t = 16'sh7fff;
        end
        else if (tq < -29'sd32768)
        begin
            out_next.t = 16'sh8000;
        end
        else
        begin
            out_next.t = tq[15:0];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int s = 0; s <= bpc_pkg::D1_STG; s++)
            begin
                dv_vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_vld_reg    <= in_vld;
            s2_vld_reg    <= s1_vld_reg;
            dv_vld_reg[0] <= s2_vld_reg;
            for (int s = 1; s <= bpc_pkg::D1_STG; s++)
            begin
                dv_vld_reg[s] <= dv_vld_reg[s-1];
            end
            out_vld_reg <= dv_vld_reg[bpc_pkg::D1_STG];
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg    <= prod_next;
            s1_up_reg      <= raw_pressure;
            s2_x1_reg      <= x1_next;
            s2_den_reg     <= den_next;
            s2_up_reg      <= s1_up_reg;
            dv_rem_reg[0]  <= '0;
            dv_nq_reg[0]   <= {mcm[15:0], 11'b0};
            dv_den_reg[0]  <= denw[bpc_pkg::D1_W-1:0];
            dv_side_reg[0] <= side0_next;
            for (int s = 1; s <= bpc_pkg::D1_STG; s++)
            begin
                dv_rem_reg[s]  <= dv_rem_next[s];
                dv_nq_reg[s]   <= dv_nq_next[s];
                dv_den_reg[s]  <= dv_den_reg[s-1];
                dv_side_reg[s] <= dv_side_reg[s-1];
            end
            out_reg <= out_next;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_data = out_reg;

endmodule

`default_nettype wire

// File: rtl/bpc_coef.sv
// Pressure coefficient section: B6, B3, B4 and B7
`default_nettype none

module bpc_coef (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  bpc_pkg::tmp_t  in_data,
    input  bpc_pkg::cfg_t  cfg,
    output logic           out_vld,
    output bpc_pkg::pdin_t out_data
);

    localparam int NSTG = 8;

    typedef struct packed {
        logic signed [15:0] t;
        logic               err;
        logic [18:0]        up;
    } side_t;

    logic  vld_reg  [1:NSTG];
    side_t side_reg [1:NSTG];

    // Stage registers
    logic signed [29:0] s1_b6_reg;
    logic [28:0]        s1_bm_reg;
    logic [57:0]        s2_sqf_reg;
    logic signed [45:0] s2_pac2_reg;
    logic signed [45:0] s2_pac3_reg;
    logic [22:0]        s3_sqh_reg;
    logic [22:0]        s3_sql_reg;
    logic signed [34:0] s3_x2a_reg;
    logic signed [32:0] s3_x1c_reg;
    logic signed [39:0] s4_pb2h_reg;
    logic signed [39:0] s4_pb2l_reg;
    logic signed [39:0] s4_pb1h_reg;
    logic signed [39:0] s4_pb1l_reg;
    logic signed [34:0] s4_x2a_reg;
    logic signed [32:0] s4_x1c_reg;
    logic signed [53:0] s5_x3a_reg;
    logic signed [45:0] s5_x3b_reg;
    logic [31:0]        s6_b3_reg;
    logic [31:0]        s6_m_reg;
    logic [16:0]        s7_b4_reg;
    logic [31:0]        s7_d_reg;
    bpc_pkg::pdin_t     s8_out_reg;

    // Combinational results
    logic signed [29:0] b6;
    logic [45:0]        sq;
    logic signed [63:0] x3a;
    logic signed [63:0] x3b;
    logic [31:0]        b3_lo;
    logic [31:0]        m_lo;
    logic [47:0]        p4;
    logic [47:0]        p7;
    logic [15:0]        fac;

    // Stage 1: B6 and its magnitude
    assign b6 = 30'(in_data.b5) - bpc_pkg::B6_OFFSET;

    // Stage 3: (B6*B6) >> 12
    assign sq = s2_sqf_reg[57:12];

    // Stage 5: B2*SQ >> 11 + AC2*B6 >> 11, (AC3*B6 >> 13 + B1*SQ >> 16 + 2) >> 2
    always_comb
    begin
        logic signed [63:0] b2sq;
        logic signed [63:0] b1sq;
        b2sq = (64'(s4_pb2h_reg) <<< 23) + 64'(s4_pb2l_reg);
        b1sq = (64'(s4_pb1h_reg) <<< 23) + 64'(s4_pb1l_reg);
        x3a  = (b2sq >>> 11) + 64'(s4_x2a_reg);
        x3b  = (64'(s4_x1c_reg) + (b1sq >>> 16) + 64'sd2) >>> 2;
    end

    // Stage 6: low word of B3 and of X3 + 32768
    always_comb
    begin
        logic signed [63:0] v;
        logic signed [63:0] w;
        logic signed [63:0] mm;
        v     = (64'(cfg.ac1) <<< 2) + 64'(s5_x3a_reg);
        w     = (v <<< cfg.oss) + 64'sd2;
        w     = w >>> 2;
        b3_lo = w[31:0];
        mm    = 64'(s5_x3b_reg) + bpc_pkg::B4_BIAS;
        m_lo  = mm[31:0];
    end

    // Stage 7 and 8 products, wrapped to 32 bits
    assign p4  = cfg.ac4 * s6_m_reg;
    assign fac = bpc_pkg::B7_SCALE >> cfg.oss;
    assign p7  = s7_d_reg * fac;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= NSTG; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= in_vld;
            for (int s = 2; s <= NSTG; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1].t   <= in_data.t;
            side_reg[1].err <= in_data.err;
            side_reg[1].up  <= in_data.up;
            for (int s = 2; s <= NSTG; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            s1_b6_reg   <= b6;
            s1_bm_reg   <= b6[29] ? 29'(-b6) : b6[28:0];
            s2_sqf_reg  <= s1_bm_reg * s1_bm_reg;
            s2_pac2_reg <= cfg.ac2 * s1_b6_reg;
            s2_pac3_reg <= cfg.ac3 * s1_b6_reg;
            s3_sqh_reg  <= sq[45:23];
            s3_sql_reg  <= sq[22:0];
            s3_x2a_reg  <= s2_pac2_reg[45:11];
            s3_x1c_reg  <= s2_pac3_reg[45:13];
            s4_pb2h_reg <= cfg.b2 * $signed({1'b0, s3_sqh_reg});
            s4_pb2l_reg <= cfg.b2 * $signed({1'b0, s3_sql_reg});
            s4_pb1h_reg <= cfg.b1 * $signed({1'b0, s3_sqh_reg});
            s4_pb1l_reg <= cfg.b1 * $signed({1'b0, s3_sql_reg});
            s4_x2a_reg  <= s3_x2a_reg;
            s4_x1c_reg  <= s3_x1c_reg;
            s5_x3a_reg  <= x3a[53:0];
            s5_x3b_reg  <= x3b[45:0];
            s6_b3_reg   <= b3_lo;
            s6_m_reg    <= m_lo;
            s7_b4_reg   <= p4[31:15];
            s7_d_reg    <= {13'b0, side_reg[6].up} - s6_b3_reg;
            s8_out_reg.b7  <= p7[31:0];
            s8_out_reg.b4  <= s7_b4_reg;
            s8_out_reg.t   <= side_reg[7].t;
            s8_out_reg.err <= side_reg[7].err | (s7_b4_reg == 17'd0);
        end
    end

    assign out_vld  = vld_reg[NSTG];
    assign out_data = s8_out_reg;

endmodule

`default_nettype wire

// File: rtl/bpc_pdiv.sv
// Pressure divider: pipelined unsigned B7 / B4 with the top-bit split
`default_nettype none

module bpc_pdiv (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  bpc_pkg::pdin_t in_data,
    output logic           out_vld,
    output bpc_pkg::praw_t out_data
);

    typedef struct packed {
        logic signed [15:0] t;
        logic               err;
        logic               big;
    } side_t;

    logic                     vld_reg  [0:bpc_pkg::D2_STG];
    logic [bpc_pkg::D2_W-1:0] rem_reg  [0:bpc_pkg::D2_STG];
    logic [bpc_pkg::D2_N-1:0] nq_reg   [0:bpc_pkg::D2_STG];
    logic [bpc_pkg::D2_W-1:0] den_reg  [0:bpc_pkg::D2_STG];
    side_t                    side_reg [0:bpc_pkg::D2_STG];
    logic [bpc_pkg::D2_W-1:0] rem_next [1:bpc_pkg::D2_STG];
    logic [bpc_pkg::D2_N-1:0] nq_next  [1:bpc_pkg::D2_STG];

    logic                     out_vld_reg;
    bpc_pkg::praw_t           out_reg;
    logic [31:0]              q_fin;

    // Restoring divide, D2_BPS quotient bits per stage
    always_comb
    begin
        logic [bpc_pkg::D2_W-1:0] r;
        logic [bpc_pkg::D2_N-1:0] q;
        logic [bpc_pkg::D2_W:0]   tmp;
        for (int s = 1; s <= bpc_pkg::D2_STG; s++)
        begin
            r = rem_reg[s-1];
            q = nq_reg[s-1];
            for (int i = 0; i < bpc_pkg::D2_BPS; i++)
            begin
                tmp = {r, q[bpc_pkg::D2_N-1]};
                q   = {q[bpc_pkg::D2_N-2:0], 1'b0};
                if (tmp >= {1'b0, den_reg[s-1]})
                begin
                    tmp  = tmp - {1'b0, den_reg[s-1]};
                    q[0] = 1'b1;
                end
                r = tmp[bpc_pkg::D2_W-1:0];
            end
            rem_next[s] = r;
            nq_next[s]  = q;
        end
    end

    // Large B7 divides first and doubles after, wrapping to 32 bits
    assign q_fin = side_reg[bpc_pkg::D2_STG].big ?
                   {nq_reg[bpc_pkg::D2_STG][30:0], 1'b0} : nq_reg[bpc_pkg::D2_STG];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            for (int s = 0; s <= bpc_pkg::D2_STG; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s <= bpc_pkg::D2_STG; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            out_vld_reg <= vld_reg[bpc_pkg::D2_STG];
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]      <= '0;
            nq_reg[0]       <= in_data.b7[31] ? in_data.b7 : {in_data.b7[30:0], 1'b0};
            den_reg[0]      <= in_data.b4;
            side_reg[0].t   <= in_data.t;
            side_reg[0].err <= in_data.err;
            side_reg[0].big <= in_data.b7[31];
            for (int s = 1; s <= bpc_pkg::D2_STG; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                nq_reg[s]   <= nq_next[s];
                den_reg[s]  <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
            out_reg.p   <= q_fin;
            out_reg.t   <= side_reg[bpc_pkg::D2_STG].t;
            out_reg.err <= side_reg[bpc_pkg::D2_STG].err;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_data = out_reg;

endmodule

`default_nettype wire

// File: rtl/bpc_corr.sv
// Pressure correction polynomial, saturation and output register
`default_nettype none

module bpc_corr (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  bpc_pkg::praw_t in_data,
    output logic           out_vld,
    output bpc_pkg::res_t  out_data
);

    logic               c1_vld_reg;
    logic [47:0]        c1_sq_reg;
    logic signed [47:0] c1_lin_reg;
    logic [31:0]        c1_p_reg;
    logic signed [15:0] c1_t_reg;
    logic               c1_err_reg;

    logic               c2_vld_reg;
    logic [43:0]        c2_x1_reg;
    logic signed [31:0] c2_x2_reg;
    logic [31:0]        c2_p_reg;
    logic signed [15:0] c2_t_reg;
    logic               c2_err_reg;

    logic               c3_vld_reg;
    bpc_pkg::res_t      c3_out_reg;
    bpc_pkg::res_t      c3_out_next;

    logic [59:0]        p_sq;

    // Stage 2: (p>>8)^2 * 3038 >> 16
    assign p_sq = c1_sq_reg * bpc_pkg::C_SQ;

    // Stage 3: p + (X1 + X2 + 3791) >> 4, clamp, error forces zero
    always_comb
    begin
        logic signed [63:0] corr;
        logic signed [63:0] pp;
        corr = ($signed({20'b0, c2_x1_reg}) + 64'(c2_x2_reg) + bpc_pkg::C_OFF) >>> 4;
        pp   = $signed({32'b0, c2_p_reg}) + corr;
        c3_out_next.err = c2_err_reg;
        if (c2_err_reg)
        begin
            c3_out_next.t  = '0;
            c3_out_next.pa = '0;
        end
        else
        begin
            c3_out_next.t = c2_t_reg;
            if (pp > 64'sd262143)
            begin
                c3_out_next.pa = '1;
            end
            else if (pp < 64'sd0)
            begin
                c3_out_next.pa = '0;
            end
            else
            begin
                c3_out_next.pa = pp[17:0];
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            c3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_vld_reg <= in_vld;
            c2_vld_reg <= c1_vld_reg;
            c3_vld_reg <= c2_vld_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_sq_reg  <= in_data.p[31:8] * in_data.p[31:8];
            c1_lin_reg <= $signed({1'b0, in_data.p}) * bpc_pkg::C_LIN;
            c1_p_reg   <= in_data.p;
            c1_t_reg   <= in_data.t;
            c1_err_reg <= in_data.err;
            c2_x1_reg  <= p_sq[59:16];
            c2_x2_reg  <= c1_lin_reg[47:16];
            c2_p_reg   <= c1_p_reg;
            c2_t_reg   <= c1_t_reg;
            c2_err_reg <= c1_err_reg;
            c3_out_reg <= c3_out_next;
        end
    end

    assign out_vld  = c3_vld_reg;
    assign out_data = c3_out_reg;

endmodule

`default_nettype wire

// File: rtl/barometric_pressure_compensation_core.sv
// Top level: register port, stall control and section pipeline
`default_nettype none

// Integer barometric compensation. Each input beat carries one raw temperature
// and one raw pressure word; each output beat carries temperature in 0.1 degree,
// pressure in pascals and a divide error flag (results forced to zero). The
// pipeline takes one beat per clock unless the output is held. Each beat passes
// through the temperature section (its 27-bit signed divider retires 3 bits a
// stage), the pressure coefficients, the 32-bit pressure divider (4 bits a
// stage) and the correction polynomial. A held output beat holds the whole
// pipeline and drops s_axis_tready in the same cycle. The user writes calibration
// registers through the APB port only while the core is idle; the core does not enforce it.
module barometric_pressure_compensation_core (
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [15:0] raw_temp, [34:16] raw_pressure, zero pad
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [15:0] temperature_tenths, [33:16] pressure_pa, pad
    output logic        m_axis_tuser   // [0] divide_error
);

    logic [31:0] ac1_ac2_reg;
    logic [31:0] ac3_ac4_reg;
    logic [31:0] ac5_ac6_reg;
    logic [31:0] b1_b2_reg;
    logic [31:0] mc_md_reg;
    logic [1:0]  oss_reg;
    logic        wr_en;

    bpc_pkg::cfg_t  cfg;
    logic           en;
    logic           tmp_vld;
    bpc_pkg::tmp_t  tmp_data;
    logic           pdi_vld;
    bpc_pkg::pdin_t pdi_data;
    logic           praw_vld;
    bpc_pkg::praw_t praw_data;
    logic           res_vld;
    bpc_pkg::res_t  res_data;

    // Register writes
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_ac2_reg <= '0;
            ac3_ac4_reg <= '0;
            ac5_ac6_reg <= '0;
            b1_b2_reg   <= '0;
            mc_md_reg   <= '0;
            oss_reg     <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                bpc_pkg::REG_AC1_AC2: ac1_ac2_reg <= pwdata;
                bpc_pkg::REG_AC3_AC4: ac3_ac4_reg <= pwdata;
                bpc_pkg::REG_AC5_AC6: ac5_ac6_reg <= pwdata;
                bpc_pkg::REG_B1_B2:   b1_b2_reg   <= pwdata;
                bpc_pkg::REG_MC_MD:   mc_md_reg   <= pwdata;
                bpc_pkg::REG_OSS:     oss_reg     <= pwdata[1:0];
                default:              ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (paddr[4:2])
            bpc_pkg::REG_AC1_AC2: prdata = ac1_ac2_reg;
            bpc_pkg::REG_AC3_AC4: prdata = ac3_ac4_reg;
            bpc_pkg::REG_AC5_AC6: prdata = ac5_ac6_reg;
            bpc_pkg::REG_B1_B2:   prdata = b1_b2_reg;
            bpc_pkg::REG_MC_MD:   prdata = mc_md_reg;
            bpc_pkg::REG_OSS:     prdata = {30'b0, oss_reg};
            default:              prdata = '0;
        endcase
    end

    // Coefficient unpack
    always_comb
    begin
        cfg.ac1 = ac1_ac2_reg[31:16];
        cfg.ac2 = ac1_ac2_reg[15:0];
        cfg.ac3 = ac3_ac4_reg[31:16];
        cfg.ac4 = ac3_ac4_reg[15:0];
        cfg.ac5 = ac5_ac6_reg[31:16];
        cfg.ac6 = ac5_ac6_reg[15:0];
        cfg.b1  = b1_b2_reg[31:16];
        cfg.b2  = b1_b2_reg[15:0];
        cfg.mc  = mc_md_reg[31:16];
        cfg.md  = mc_md_reg[15:0];
        cfg.oss = oss_reg;
    end

    // Pipeline advances unless a finished beat is held at the output
    assign en            = !res_vld || m_axis_tready;
    assign s_axis_tready = en;

    bpc_temp u_temp (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (s_axis_tvalid),
        .raw_temp     (s_axis_tdata[15:0]),
        .raw_pressure (s_axis_tdata[34:16]),
        .cfg          (cfg),
        .out_vld      (tmp_vld),
        .out_data     (tmp_data)
    );

    bpc_coef u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (tmp_vld),
        .in_data  (tmp_data),
        .cfg      (cfg),
        .out_vld  (pdi_vld),
        .out_data (pdi_data)
    );

    bpc_pdiv u_pdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (pdi_vld),
        .in_data  (pdi_data),
        .out_vld  (praw_vld),
        .out_data (praw_data)
    );

    bpc_corr u_corr (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (praw_vld),
        .in_data  (praw_data),
        .out_vld  (res_vld),
        .out_data (res_data)
    );

    // Output beat
    assign m_axis_tvalid = res_vld;
    assign m_axis_tdata  = {6'b0, res_data.pa, res_data.t};
    assign m_axis_tuser  = res_data.err;

endmodule

`default_nettype wire

// File: rtl/bpc_checker.sv
// Port-level checks for the compensation core, bound to the top level
`default_nettype none

`include "barometric_pressure_compensation_core_macros.svh"

module bpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // Held output beat keeps its payload
    `BPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Divide error gives zero results
    `BPC_ASSERT_SAME(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[33:0] == 34'd0)

    // Pad bits stay clear
    `BPC_ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[39:34] == 6'd0)

    // Input side stalls exactly when an output beat is held
    `BPC_ASSERT_SAME(a_stall, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

endmodule

bind barometric_pressure_compensation_core bpc_checker u_bpc_checker (.*);

`default_nettype wire
